>>> hw/rtl/mcr_pkg.sv
package mcr_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned IN_COORD_W = 10;
  localparam int unsigned PIX_W      = 12;
  localparam int unsigned DEC_W      = 16;

  // Eight mirrored pixels per point group.
  localparam int unsigned GROUP_SIZE = 8;
  localparam int unsigned IDX_W      = $clog2(GROUP_SIZE);

  // Midpoint decision constants.
  localparam int unsigned DEC_INIT      = 3;
  localparam int unsigned DEC_INC_DIAG  = 10;
  localparam int unsigned DEC_INC_AXIS  = 6;

  // Request kinds carried on the input tuser.
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_e;

  typedef logic [IN_COORD_W-1:0] in_coord_t;
  typedef logic [PIX_W-1:0]      pix_t;
  typedef logic [DEC_W-1:0]      dec_t;

  typedef struct packed {
    action_e   action;
    in_coord_t center_x;
    in_coord_t center_y;
    in_coord_t radius;
  } item_t;

  // One point group: center and octant offsets resized to pixel width.
  typedef struct packed {
    pix_t h;
    pix_t k;
    pix_t x;
    pix_t y;
    logic done;
  } group_t;

endpackage

>>> hw/rtl/mcr_step.sv
module mcr_step #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mcr_pkg::item_t item_i,
  input  logic           fire_i,
  output logic           emit_o,
  output mcr_pkg::group_t grp_o
);
  import mcr_pkg::*;

  localparam int unsigned OFF_W = COORD_BITS + 1;
  localparam int unsigned CMP_W = OFF_W + 2;

  logic [OFF_W-1:0]      offset_x_q, offset_x_d;
  logic [OFF_W-1:0]      offset_y_q, offset_y_d;
  dec_t                  decision_q, decision_d;
  logic [COORD_BITS-1:0] center_col_q, center_col_d;
  logic [COORD_BITS-1:0] center_row_q, center_row_d;
  logic                  drawing_q, drawing_d;

  logic                  start;
  logic [COORD_BITS-1:0] r;
  logic [OFF_W-1:0]      x, y;
  dec_t                  d, dx, dy, nd;
  logic                  d_pos;
  logic [CMP_W-1:0]      nx_w, ny_w;
  logic                  done;

  assign start = (item_i.action == ACT_START);
  assign r     = COORD_BITS'(item_i.radius);

  // A start request replaces the stored circle before the group is formed.
  always_comb begin
    x = offset_x_q;
    y = offset_y_q;
    d = decision_q;
    center_col_d = center_col_q;
    center_row_d = center_row_q;
    emit_o = drawing_q;
    if (start) begin
      x = '0;
      y = OFF_W'(r);
      d = DEC_W'(DEC_INIT) - (DEC_W'(r) << 1);
      center_col_d = COORD_BITS'(item_i.center_x);
      center_row_d = COORD_BITS'(item_i.center_y);
      emit_o = 1'b1;
    end
  end

  assign d_pos = ~d[DEC_W-1];
  assign dx    = DEC_W'(x);
  assign dy    = DEC_W'(y);
  assign nd    = d_pos ? d + ((dx - dy) << 2) + DEC_W'(DEC_INC_DIAG)
                       : d + (dx << 2) + DEC_W'(DEC_INC_AXIS);

  // y may step to minus one at zero radius, so the compare is signed.
  assign nx_w = CMP_W'(x) + CMP_W'(1);
  assign ny_w = CMP_W'(y) - CMP_W'(d_pos);
  assign done = $signed(nx_w) > $signed(ny_w);

  assign offset_x_d = nx_w[OFF_W-1:0];
  assign offset_y_d = ny_w[OFF_W-1:0];
  assign decision_d = nd;
  assign drawing_d  = ~done;

  assign grp_o.h    = PIX_W'(center_col_d);
  assign grp_o.k    = PIX_W'(center_row_d);
  assign grp_o.x    = PIX_W'(x);
  assign grp_o.y    = PIX_W'(y);
  assign grp_o.done = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q   <= '0;
      offset_y_q   <= '0;
      decision_q   <= '0;
      center_col_q <= '0;
      center_row_q <= '0;
      drawing_q    <= 1'b0;
    end else if (fire_i && emit_o) begin
      offset_x_q   <= offset_x_d;
      offset_y_q   <= offset_y_d;
      decision_q   <= decision_d;
      center_col_q <= center_col_d;
      center_row_q <= center_row_d;
      drawing_q    <= drawing_d;
    end
  end

endmodule

>>> hw/rtl/mcr_emit.sv
module mcr_emit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  mcr_pkg::group_t       grp_i,
  output logic                  grp_ready_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [23:0]           m_axis_tdata_o,
  output logic                  m_axis_tlast_o,
  output logic                  m_axis_tuser_o
);
  import mcr_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GROUP_SIZE - 1);

  group_t           grp_q;
  logic             gv_q;
  logic [IDX_W-1:0] idx_q;
  logic             ov_q;
  pix_t             px_q, py_q, px_d, py_d;
  logic             last_q, done_q;

  logic pix_load;
  logic is_last;
  pix_t colo, rowo;

  assign pix_load    = gv_q && (!ov_q || m_axis_tready_i);
  assign is_last     = (idx_q == LAST_IDX);
  assign grp_ready_o = !gv_q || (pix_load && is_last);

  // Upper half of the group swaps the roles of x and y; the low index bits
  // pick the sign of the column and row offsets.
  assign colo = idx_q[2] ? grp_q.y : grp_q.x;
  assign rowo = idx_q[2] ? grp_q.x : grp_q.y;
  assign px_d = idx_q[0] ? grp_q.h - colo : grp_q.h + colo;
  assign py_d = idx_q[1] ? grp_q.k - rowo : grp_q.k + rowo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gv_q  <= 1'b0;
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (load_i) begin
        gv_q  <= 1'b1;
        idx_q <= '0;
      end else if (pix_load) begin
        if (is_last) begin
          gv_q <= 1'b0;
        end
        idx_q <= idx_q + IDX_W'(1);
      end
      if (pix_load) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_i;
    end
    if (pix_load) begin
      px_q   <= px_d;
      py_q   <= py_d;
      last_q <= is_last;
      done_q <= grp_q.done;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {py_q, px_q};
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tuser_o  = done_q;

endmodule

>>> hw/rtl/midpoint_circle_rasterizer.sv
// Midpoint circle rasterizer with eight-way symmetry. A start request (tuser
// low) loads a center and a radius and at once yields the first group of
// eight mirrored pixels; each step request (tuser high) yields the next group
// until the octant offset x passes y, after which step requests are taken
// and yield nothing until the next start. Pixels come out one per cycle
// unless tready is low, in the order (cx+x,cy+y) (cx-x,cy+y) (cx+x,cy-y)
// (cx-x,cy-y) (cx+y,cy+x) (cx-y,cy+x) (cx+y,cy-x) (cx-y,cy-x) as 12-bit
// two's complement values that may fall off the image; tlast marks the
// eighth pixel of a group and tuser is high on every pixel of the circle's
// final group. Pixels on the axes and the diagonal are repeated, not merged.
// A request is held in an input register, the decision update and the group
// are formed combinationally, and a serializer drives a registered output,
// so the request rate is set by the output port; a step request on an idle
// rasterizer is taken without waiting on the output. The first pixel of a
// group passes the input register, group buffer and output register.
module midpoint_circle_rasterizer #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [9:0] center_x, [19:10] center_y,
                                        // [29:20] radius, [31:30] zero
  input  logic        s_axis_tuser_i,   // [0] action: 0 start, 1 step
  // Pixel stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [11:0] pixel_x, [23:12] pixel_y
  output logic        m_axis_tlast_o,   // last_of_group
  output logic        m_axis_tuser_o    // [0] circle_done
);
  import mcr_pkg::*;

  logic   in_valid_q;
  item_t  item_q;
  logic   in_fire;
  logic   step_fire;
  logic   emit;
  logic   grp_ready;
  group_t grp;

  // The input register frees up whenever its request moves into the step
  // stage, so a new request can enter in the same cycle.
  assign step_fire       = in_valid_q && (!emit || grp_ready);
  assign s_axis_tready_o = !in_valid_q || step_fire;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.action   <= action_e'(s_axis_tuser_i);
      item_q.center_x <= s_axis_tdata_i[9:0];
      item_q.center_y <= s_axis_tdata_i[19:10];
      item_q.radius   <= s_axis_tdata_i[29:20];
    end
  end

  // Circle state and the midpoint decision update.
  mcr_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_q),
    .fire_i (step_fire),
    .emit_o (emit),
    .grp_o  (grp)
  );

  // Group buffer, pixel mirroring and the output register.
  mcr_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (step_fire && emit),
    .grp_i           (grp),
    .grp_ready_o     (grp_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

`ifndef SYNTHESIS
  // Back-pressure on the request side only comes from a held request.
  a_ready_when_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q
  ) else $error("request side stalled with an empty input register");

  // Within a group the next pixel follows at once and keeps the final flag.
  a_group_contiguous: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=>
      (m_axis_tvalid_o && (m_axis_tuser_o == $past(m_axis_tuser_o)))
  ) else $error("pixel group broken or final flag changed inside a group");

  // A group is loaded only when the buffer can take it.
  a_no_overrun: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (step_fire && emit) |-> grp_ready
  ) else $error("group loaded over an unfinished group");
`endif

endmodule
